>>> rtl/core/mpmsu_pkg.sv
// Shared types, codes and saturating arithmetic for the strain update block.
// Used by every module of the block; depends on nothing.
package mpmsu_pkg;

   localparam int VALUE_WIDTH = 48;
   localparam int FRAC_BITS   = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam value_type VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [3:0] QTY_STRAIN_XX = 4'd0;
   localparam logic [3:0] QTY_STRAIN_YY = 4'd1;
   localparam logic [3:0] QTY_STRAIN_ZZ = 4'd2;
   localparam logic [3:0] QTY_STRAIN_XY = 4'd3;
   localparam logic [3:0] QTY_STRAIN_YZ = 4'd4;
   localparam logic [3:0] QTY_STRAIN_ZX = 4'd5;
   localparam logic [3:0] QTY_ROT_XY    = 4'd6;
   localparam logic [3:0] QTY_ROT_YZ    = 4'd7;
   localparam logic [3:0] QTY_ROT_ZX    = 4'd8;
   localparam logic [3:0] QTY_VOLUME    = 4'd9;
   localparam logic [3:0] QTY_LEN_X     = 4'd10;
   localparam logic [3:0] QTY_LEN_Y     = 4'd11;
   localparam logic [3:0] QTY_LEN_Z     = 4'd12;

   localparam logic [1:0] OP_NODE = 2'd0;
   localparam logic [1:0] OP_VOL  = 2'd1;
   localparam logic [1:0] OP_LEN  = 2'd2;

   typedef struct packed {
      value_type grad_x;
      value_type grad_y;
      value_type grad_z;
      value_type disp_x;
      value_type disp_y;
      value_type disp_z;
      value_type volume_old;
      value_type length_x_old;
      value_type length_y_old;
      value_type length_z_old;
      logic      last_node;
   } req_type;

   typedef struct packed {
      logic [3:0] quantity;
      value_type  value;
      logic       bad_jacobian;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       mul_start;
      logic [1:0] mul_op;
      logic       acc_en;
      logic       trace_en;
      logic       vol_en;
      logic       cbrt_start;
      logic       len_en;
      logic       len_pass;
      logic       emit_en;
      logic       load_id;
      logic [1:0] row;
      logic [1:0] col;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic cbrt_done;
      logic last_node;
      logic jac_pos;
   } sts_type;

   function automatic value_type sadd(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic value_type ssub(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic value_type half_diff(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] d;
      d = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      return d[VALUE_WIDTH:1];
   endfunction

endpackage

>>> rtl/core/mpmsu_mul.sv
// Sequential signed fixed-point multiplier: four half-width partial products,
// then rounding and saturation. Depends on mpmsu_pkg.
module mpmsu_mul #(
   parameter int FRAC_BITS = mpmsu_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mpmsu_pkg::value_type a,
   input  mpmsu_pkg::value_type b,
   output logic                 done,
   output mpmsu_pkg::value_type result
);

   localparam int W  = mpmsu_pkg::VALUE_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int AW = 4 * H;

   logic [2*H-1:0] ma_ff, mb_ff, ma_in, mb_in;
   logic           neg_ff;
   logic [AW-1:0]  acc_ff, acc_in;
   logic [2*H-1:0] prod_ff;
   logic [1:0]     sh_ff;
   logic           pvld_ff;
   logic [2:0]     cnt_ff;
   logic           run_ff;
   logic           done_ff;
   mpmsu_pkg::value_type res_ff, res_in;

   logic [H-1:0]   ah, bh;
   logic [AW:0]    rnd, qv, lim;
   logic [AW-1:0]  addend;

   always_comb begin
      ma_in = (2*H)'(a[W-1] ? -a : a);
      mb_in = (2*H)'(b[W-1] ? -b : b);
      ah = cnt_ff[1] ? ma_ff[2*H-1:H] : ma_ff[H-1:0];
      bh = cnt_ff[0] ? mb_ff[2*H-1:H] : mb_ff[H-1:0];
      case (sh_ff)
         2'd0:    addend = AW'(prod_ff);
         2'd1:    addend = AW'(prod_ff) << H;
         2'd2:    addend = AW'(prod_ff) << (2 * H);
         default: addend = '0;
      endcase
      acc_in = pvld_ff ? acc_ff + addend : acc_ff;
      rnd = {1'b0, acc_ff} + ((AW+1)'(1) << (FRAC_BITS - 1));
      qv  = rnd >> FRAC_BITS;
      lim = neg_ff ? ((AW+1)'(1) << (W - 1)) : (AW+1)'(mpmsu_pkg::VMAX);
      if (qv > lim) begin
         qv = lim;
      end
      res_in = neg_ff ? -mpmsu_pkg::value_type'(qv[W-1:0])
                      : mpmsu_pkg::value_type'(qv[W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         pvld_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            ma_ff   <= ma_in;
            mb_ff   <= mb_in;
            neg_ff  <= a[W-1] ^ b[W-1];
            acc_ff  <= '0;
            cnt_ff  <= '0;
            run_ff  <= 1'b1;
            pvld_ff <= 1'b0;
         end else if (run_ff) begin
            prod_ff <= ah * bh;
            sh_ff   <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pvld_ff <= (cnt_ff < 3'd4);
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               res_ff  <= res_in;
               done_ff <= 1'b1;
               run_ff  <= 1'b0;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> rtl/core/mpmsu_cbrt.sv
// Digit-by-digit cube root, three radicand bits per cycle, floored fixed point.
// Depends on mpmsu_pkg.
module mpmsu_cbrt #(
   parameter int FRAC_BITS = mpmsu_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mpmsu_pkg::value_type j,
   output logic                 done,
   output mpmsu_pkg::value_type root
);

   localparam int W    = mpmsu_pkg::VALUE_WIDTH;
   localparam int NB   = W - 1 + 2 * FRAC_BITS;
   localparam int NG   = (NB + 2) / 3;
   localparam int NW   = 3 * NG;
   localparam int RW   = 2 * NG + 5;
   localparam int CNTW = $clog2(NG + 1);
   localparam int CW   = (NG > W ? NG : W) + 1;

   logic [NW-1:0]   n_ff, n_in;
   logic [RW-1:0]   r_ff, r_in;
   logic [NG-1:0]   y_ff, y_in;
   logic [2*NG-1:0] ysq_ff, ysq_in;
   logic [CNTW-1:0] cnt_ff;
   logic            run_ff;
   logic            done_ff;
   mpmsu_pkg::value_type root_ff, root_in;

   logic [NG-1:0]   y2;
   logic [2*NG-1:0] y2sq;
   logic [RW-1:0]   rsh, bnd;

   always_comb begin
      y2   = {y_ff[NG-2:0], 1'b0};
      y2sq = {ysq_ff[2*NG-3:0], 2'b00};
      rsh  = {r_ff[RW-4:0], n_ff[NW-1:NW-3]};
      bnd  = RW'(y2sq) + RW'({y2sq, 1'b0}) + RW'(y2) + RW'({y2, 1'b0}) + RW'(1);
      n_in = {n_ff[NW-4:0], 3'b000};
      if (rsh >= bnd) begin
         r_in   = rsh - bnd;
         y_in   = y2 + NG'(1);
         ysq_in = y2sq + (2*NG)'({y2, 1'b0}) + (2*NG)'(1);
      end else begin
         r_in   = rsh;
         y_in   = y2;
         ysq_in = y2sq;
      end
      if (CW'(y_in) > CW'(mpmsu_pkg::VMAX)) begin
         root_in = mpmsu_pkg::VMAX;
      end else begin
         root_in = mpmsu_pkg::value_type'(y_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff   <= NW'({j[W-2:0], {(2*FRAC_BITS){1'b0}}});
            r_ff   <= '0;
            y_ff   <= '0;
            ysq_ff <= '0;
            cnt_ff <= CNTW'(NG);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            n_ff   <= n_in;
            r_ff   <= r_in;
            y_ff   <= y_in;
            ysq_ff <= ysq_in;
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               root_ff <= root_in;
               done_ff <= 1'b1;
               run_ff  <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/core/mpmsu_ctrl.sv
// Controller state machine that sequences node products, the per-point tail
// and result emission. Depends on mpmsu_pkg.
module mpmsu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output mpmsu_pkg::cmd_type cmd,
   input  mpmsu_pkg::sts_type sts
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_NODE_MUL  = 4'd1;
   localparam logic [3:0] S_NODE_WAIT = 4'd2;
   localparam logic [3:0] S_TRACE     = 4'd3;
   localparam logic [3:0] S_VOL_MUL   = 4'd4;
   localparam logic [3:0] S_VOL_WAIT  = 4'd5;
   localparam logic [3:0] S_ROOT      = 4'd6;
   localparam logic [3:0] S_ROOT_WAIT = 4'd7;
   localparam logic [3:0] S_LEN_MUL   = 4'd8;
   localparam logic [3:0] S_LEN_WAIT  = 4'd9;
   localparam logic [3:0] S_LEN_PASS  = 4'd10;
   localparam logic [3:0] S_EMIT      = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic [3:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.row  = row_ff;
      cmd.col  = col_ff;
      cmd.idx  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               row_in      = 2'd0;
               col_in      = 2'd0;
               state_in    = S_NODE_MUL;
            end
         end
         S_NODE_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = mpmsu_pkg::OP_NODE;
            state_in      = S_NODE_WAIT;
         end
         S_NODE_WAIT: begin
            if (sts.mul_done) begin
               cmd.acc_en = 1'b1;
               if (row_ff == 2'd2 && col_ff == 2'd2) begin
                  idx_in   = 4'd0;
                  state_in = sts.last_node ? S_TRACE : S_IDLE;
               end else begin
                  if (col_ff == 2'd2) begin
                     col_in = 2'd0;
                     row_in = row_ff + 2'd1;
                  end else begin
                     col_in = col_ff + 2'd1;
                  end
                  state_in = S_NODE_MUL;
               end
            end
         end
         S_TRACE: begin
            cmd.trace_en = 1'b1;
            idx_in       = idx_ff + 4'd1;
            if (idx_ff == 4'd3) begin
               state_in = S_VOL_MUL;
            end
         end
         S_VOL_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = mpmsu_pkg::OP_VOL;
            state_in      = S_VOL_WAIT;
         end
         S_VOL_WAIT: begin
            if (sts.mul_done) begin
               cmd.vol_en = 1'b1;
               state_in   = sts.jac_pos ? S_ROOT : S_LEN_PASS;
            end
         end
         S_ROOT: begin
            cmd.cbrt_start = 1'b1;
            state_in       = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sts.cbrt_done) begin
               idx_in   = 4'd0;
               state_in = S_LEN_MUL;
            end
         end
         S_LEN_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = mpmsu_pkg::OP_LEN;
            state_in      = S_LEN_WAIT;
         end
         S_LEN_WAIT: begin
            if (sts.mul_done) begin
               cmd.len_en = 1'b1;
               if (idx_ff == 4'd2) begin
                  idx_in   = 4'd0;
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_LEN_MUL;
               end
            end
         end
         S_LEN_PASS: begin
            cmd.len_pass = 1'b1;
            idx_in       = 4'd0;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_en = 1'b1;
            idx_in      = idx_ff + 4'd1;
            if (idx_ff == mpmsu_pkg::QTY_LEN_Z) begin
               cmd.load_id = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> rtl/core/mpmsu_dp.sv
// Datapath: deformation gradient, operand selection, multiplier, cube root and
// the result register. Depends on mpmsu_pkg, mpmsu_mul and mpmsu_cbrt.
module mpmsu_dp #(
   parameter int FRAC_BITS = mpmsu_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  mpmsu_pkg::req_type req_data,
   input  mpmsu_pkg::cmd_type cmd,
   output mpmsu_pkg::sts_type sts,
   output logic               rsp_valid,
   output mpmsu_pkg::rsp_type rsp_data
);

   localparam int W = mpmsu_pkg::VALUE_WIDTH;
   localparam mpmsu_pkg::value_type UNIT = (FRAC_BITS >= W - 1) ? mpmsu_pkg::VMAX :
                                           mpmsu_pkg::value_type'(64'd1 << FRAC_BITS);

   mpmsu_pkg::req_type   req_ff;
   mpmsu_pkg::value_type fg_ff [9];
   mpmsu_pkg::value_type tacc_ff, tacc_in;
   mpmsu_pkg::value_type vol_ff;
   mpmsu_pkg::value_type len_ff [3];
   mpmsu_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   mpmsu_pkg::value_type grad, disp, len_sel, mul_a, mul_b, mul_res, root;
   mpmsu_pkg::value_type e0, e1, e2, qval;
   logic [3:0]           fidx;
   logic                 mul_done, cbrt_done, jac_pos;

   always_comb begin
      case (cmd.col)
         2'd0:    grad = req_ff.grad_x;
         2'd1:    grad = req_ff.grad_y;
         default: grad = req_ff.grad_z;
      endcase
      case (cmd.row)
         2'd0:    disp = req_ff.disp_x;
         2'd1:    disp = req_ff.disp_y;
         default: disp = req_ff.disp_z;
      endcase
      case (cmd.idx[1:0])
         2'd0:    len_sel = req_ff.length_x_old;
         2'd1:    len_sel = req_ff.length_y_old;
         default: len_sel = req_ff.length_z_old;
      endcase
      case (cmd.mul_op)
         mpmsu_pkg::OP_NODE: begin
            mul_a = grad;
            mul_b = disp;
         end
         mpmsu_pkg::OP_VOL: begin
            mul_a = tacc_ff;
            mul_b = req_ff.volume_old;
         end
         mpmsu_pkg::OP_LEN: begin
            mul_a = root;
            mul_b = len_sel;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      fidx = {cmd.row, 1'b0} + {2'b00, cmd.row} + {2'b00, cmd.col};
      e0 = mpmsu_pkg::ssub(fg_ff[0], UNIT);
      e1 = mpmsu_pkg::ssub(fg_ff[4], UNIT);
      e2 = mpmsu_pkg::ssub(fg_ff[8], UNIT);
      case (cmd.idx[1:0])
         2'd0:    tacc_in = e0;
         2'd1:    tacc_in = mpmsu_pkg::sadd(tacc_ff, e1);
         2'd2:    tacc_in = mpmsu_pkg::sadd(tacc_ff, e2);
         default: tacc_in = mpmsu_pkg::sadd(UNIT, tacc_ff);
      endcase
      jac_pos = !tacc_ff[W-1] && (tacc_ff != '0);
      case (cmd.idx)
         mpmsu_pkg::QTY_STRAIN_XX: qval = e0;
         mpmsu_pkg::QTY_STRAIN_YY: qval = e1;
         mpmsu_pkg::QTY_STRAIN_ZZ: qval = e2;
         mpmsu_pkg::QTY_STRAIN_XY: qval = mpmsu_pkg::sadd(fg_ff[1], fg_ff[3]);
         mpmsu_pkg::QTY_STRAIN_YZ: qval = mpmsu_pkg::sadd(fg_ff[7], fg_ff[5]);
         mpmsu_pkg::QTY_STRAIN_ZX: qval = mpmsu_pkg::sadd(fg_ff[6], fg_ff[2]);
         mpmsu_pkg::QTY_ROT_XY:    qval = mpmsu_pkg::half_diff(fg_ff[3], fg_ff[1]);
         mpmsu_pkg::QTY_ROT_YZ:    qval = mpmsu_pkg::half_diff(fg_ff[5], fg_ff[7]);
         mpmsu_pkg::QTY_ROT_ZX:    qval = mpmsu_pkg::half_diff(fg_ff[2], fg_ff[6]);
         mpmsu_pkg::QTY_VOLUME:    qval = vol_ff;
         mpmsu_pkg::QTY_LEN_X:     qval = len_ff[0];
         mpmsu_pkg::QTY_LEN_Y:     qval = len_ff[1];
         mpmsu_pkg::QTY_LEN_Z:     qval = len_ff[2];
         default:                  qval = '0;
      endcase
      rsp_in.quantity     = cmd.idx;
      rsp_in.value        = qval;
      rsp_in.bad_jacobian = !jac_pos;
      rsp_in.last_result  = (cmd.idx == mpmsu_pkg::QTY_LEN_Z);
   end

   mpmsu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   mpmsu_cbrt #(.FRAC_BITS(FRAC_BITS)) u_cbrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.cbrt_start),
      .j     (tacc_ff),
      .done  (cbrt_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.trace_en) begin
         tacc_ff <= tacc_in;
      end
      if (cmd.vol_en) begin
         vol_ff <= mul_res;
      end
      if (cmd.len_en) begin
         len_ff[cmd.idx[1:0]] <= mul_res;
      end
      if (cmd.len_pass) begin
         len_ff[0] <= req_ff.length_x_old;
         len_ff[1] <= req_ff.length_y_old;
         len_ff[2] <= req_ff.length_z_old;
      end
      if (cmd.emit_en) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_id) begin
         for (int i = 0; i < 9; i++) begin
            fg_ff[i] <= (i % 4 == 0) ? UNIT : '0;
         end
      end else if (cmd.acc_en) begin
         fg_ff[fidx] <= mpmsu_pkg::sadd(fg_ff[fidx], mul_res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_en;
      end
   end

   assign sts.mul_done  = mul_done;
   assign sts.cbrt_done = cbrt_done;
   assign sts.last_node = req_ff.last_node;
   assign sts.jac_pos   = jac_pos;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

>>> rtl/core/mpm_strain_update.sv
// Top level of the material point strain update block.
// Depends on mpmsu_pkg, mpmsu_ctrl and mpmsu_dp.
//
// A request is one node of a material point and is taken when start is high
// and busy is low. Each node needs nine products on one shared multiplier that
// works in four 24x24 passes, and busy stays high while they run. A request with
// last_node set then adds the trace, the volume product, the cube root at one
// cycle per three radicand bits and the three length products, or, if the
// Jacobian is not positive, skips the root and passes the old lengths through.
// The 13 results leave one per cycle in
// quantity order, each shown for one cycle with rsp_valid; the receiver cannot
// stall them and must take every one.
module mpm_strain_update #(
   parameter int FRAC_BITS = mpmsu_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mpmsu_pkg::req_type req_data,
   output logic               rsp_valid,
   output mpmsu_pkg::rsp_type rsp_data
);

   mpmsu_pkg::cmd_type cmd;
   mpmsu_pkg::sts_type sts;

   mpmsu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   mpmsu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/mpmsu_checker.sv
// Port-level checks for mpm_strain_update, attached by the bind below.
// Depends on mpmsu_pkg.
module mpmsu_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input mpmsu_pkg::rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted request");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |=> rsp_valid)
      else $error("result burst broke off early");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |=>
      rsp_data.quantity == 4'($past(rsp_data.quantity) + 4'd1))
      else $error("results out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |-> rsp_data.quantity == mpmsu_pkg::QTY_LEN_Z)
      else $error("last result has the wrong quantity");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |=> $stable(rsp_data.bad_jacobian))
      else $error("error flag changed within a burst");

endmodule

bind mpm_strain_update mpmsu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
